// ===== hw/rtl/puset_pkg.sv =====
// ----------------------------------------------------------------------------
// puset_pkg
// Shared widths, command codes and status codes for the packed unsorted set.
// ----------------------------------------------------------------------------
package puset_pkg;

  localparam int CMD_W            = 2;
  localparam int KEY_W            = 32;
  localparam int STATUS_W         = 2;
  localparam int SLOT_W           = 7;
  localparam int ENTRY_COUNT_W    = 8;
  localparam int DEFAULT_CAPACITY = 128;

  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_PRESENT   = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/puset_if.sv =====
// ----------------------------------------------------------------------------
// puset_if
// Request and response channels of the packed unsorted set.
// ----------------------------------------------------------------------------
interface puset_req_if;
  logic                              valid;
  logic                              ready;
  logic [puset_pkg::CMD_W-1:0]       cmd;
  logic signed [puset_pkg::KEY_W-1:0] key_value;

  modport source (output valid, output cmd, output key_value, input ready);
  modport sink   (input valid, input cmd, input key_value, output ready);
endinterface

interface puset_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [puset_pkg::STATUS_W-1:0]      status;
  logic [puset_pkg::SLOT_W-1:0]        slot;
  logic [puset_pkg::ENTRY_COUNT_W-1:0] entry_count;

  modport source (output valid, output status, output slot, output entry_count, input ready);
  modport sink   (input valid, input status, input slot, input entry_count, output ready);
endinterface

// ===== hw/rtl/packed_unsorted_set.sv =====
// ----------------------------------------------------------------------------
// packed_unsorted_set
// Packed, unsorted set of 32-bit values with linear search, append insert
// and swap-with-last delete, held in a single-port-read memory.
// ----------------------------------------------------------------------------
// find and insert scan the entries held, one read a cycle, then decide; a delete
//   hit adds a move state that writes the last entry into the hole before responding
// one request at a time: the next is taken the cycle after the response is consumed
// reset: entry count cleared, memory contents left undefined until written
// ----------------------------------------------------------------------------
module packed_unsorted_set #(
  parameter int CAPACITY = puset_pkg::DEFAULT_CAPACITY
) (
  input logic         clk,
  input logic         rst,
  puset_req_if.sink   req,
  puset_rsp_if.source rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_RESP
  } state_t;

  state_t                        state;
  logic [puset_pkg::CMD_W-1:0]   cmd;
  logic [puset_pkg::KEY_W-1:0]   key;
  logic [IDX_W-1:0]              scan_idx;
  logic [IDX_W-1:0]              pos;
  logic                          hit;
  logic [CNT_W-1:0]              count;
  puset_pkg::status_t            rsp_status;
  logic [IDX_W-1:0]              rsp_slot;
  logic [CNT_W-1:0]              rsp_count;

  logic [puset_pkg::KEY_W-1:0]   mem [CAPACITY];
  logic [puset_pkg::KEY_W-1:0]   rdata;
  logic [IDX_W-1:0]              raddr;
  logic                          we;
  logic [IDX_W-1:0]              waddr;
  logic [puset_pkg::KEY_W-1:0]   wdata;

  logic                          match;
  logic                          scan_last;
  logic                          full;
  logic [IDX_W-1:0]              last_idx;

  assign match     = (rdata == key);
  assign scan_last = ((CNT_W'(scan_idx) + CNT_W'(1)) >= count);
  assign full      = (count == CNT_W'(CAPACITY));
  assign last_idx  = IDX_W'(count - CNT_W'(1));

  // memory port control
  always_comb begin
    raddr = '0;
    we    = 1'b0;
    waddr = pos;
    wdata = key;
    unique case (state)
      S_IDLE:   raddr = '0;
      S_SCAN:   raddr = IDX_W'(scan_idx + IDX_W'(1));
      S_DECIDE: begin
        raddr = last_idx;
        if (cmd == puset_pkg::CMD_INSERT && !hit && !full) begin
          we    = 1'b1;
          waddr = count[IDX_W-1:0];
        end
      end
      S_MOVE: begin
        // last entry fills the hole
        we    = 1'b1;
        waddr = pos;
        wdata = rdata;
      end
      S_RESP:   raddr = '0;
      default:  raddr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd      <= req.cmd;
            key      <= req.key_value;
            scan_idx <= '0;
            pos      <= '0;
            hit      <= 1'b0;
            state    <= (count == '0) ? S_DECIDE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (match) begin
            hit   <= 1'b1;
            pos   <= scan_idx;
            state <= S_DECIDE;
          end else if (scan_last) begin
            state <= S_DECIDE;
          end else begin
            scan_idx <= IDX_W'(scan_idx + IDX_W'(1));
          end
        end
        S_DECIDE: begin
          priority if (cmd == puset_pkg::CMD_INSERT) begin
            state <= S_RESP;
            priority if (hit) begin
              rsp_status <= puset_pkg::ST_PRESENT;
              rsp_slot   <= pos;
              rsp_count  <= count;
            end else if (full) begin
              rsp_status <= puset_pkg::ST_FULL;
              rsp_slot   <= '0;
              rsp_count  <= count;
            end else begin
              rsp_status <= puset_pkg::ST_OK;
              rsp_slot   <= count[IDX_W-1:0];
              rsp_count  <= CNT_W'(count + CNT_W'(1));
              count      <= CNT_W'(count + CNT_W'(1));
            end
          end else if (cmd == puset_pkg::CMD_DELETE) begin
            if (hit) begin
              // the last entry is read here and written into the hole in S_MOVE
              state <= S_MOVE;
            end else begin
              state      <= S_RESP;
              rsp_status <= puset_pkg::ST_NOT_FOUND;
              rsp_slot   <= pos;
              rsp_count  <= count;
            end
          end else begin
            state      <= S_RESP;
            rsp_status <= hit ? puset_pkg::ST_OK : puset_pkg::ST_NOT_FOUND;
            rsp_slot   <= pos;
            rsp_count  <= count;
          end
        end
        S_MOVE: begin
          rsp_status <= puset_pkg::ST_OK;
          rsp_slot   <= pos;
          rsp_count  <= CNT_W'(count - CNT_W'(1));
          count      <= CNT_W'(count - CNT_W'(1));
          state      <= S_RESP;
        end
        S_RESP: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_RESP);
  assign rsp.status      = rsp_status;
  assign rsp.slot        = puset_pkg::SLOT_W'(rsp_slot);
  assign rsp.entry_count = puset_pkg::ENTRY_COUNT_W'(rsp_count);

endmodule
